// File: src/fcvd_pkg.sv
package fcvd_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int INDEX_WIDTH = 16;

    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int TRIPLE_W    = 3 * INDEX_WIDTH;

    localparam int FIELD_W     = 16;
    localparam int CORNER_W    = 2;
    localparam int OUT_INDEX_W = 10;
    localparam int COUNT_W     = 11;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CORNER_W-1:0] CORNER_FIRST = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_THIRD = 2'd2;
    localparam logic [CORNER_W-1:0] CORNER_QUAD  = 2'd3;

    typedef struct packed {
        logic [TRIPLE_W-1:0] triple;
        logic [CORNER_W-1:0] corner;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } back_state_t;

endpackage

// File: src/fcvd_ram.sv
module fcvd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/fcvd_front.sv
module fcvd_front
    import fcvd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                corner_valid,
    output logic                corner_ready,
    input  logic [FIELD_W-1:0]  pos_index,
    input  logic [FIELD_W-1:0]  tex_index,
    input  logic [FIELD_W-1:0]  norm_index,
    input  logic [CORNER_W-1:0] corner,
    output logic                head_valid,
    output item_t               head_item,
    input  logic                head_pop
);

    item_t             q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    item_t             new_item;
    logic              push;
    logic              pop;

    // cast each index to the table's index width
    always_comb
    begin
        new_item.triple = {INDEX_WIDTH'(pos_index), INDEX_WIDTH'(tex_index),
                           INDEX_WIDTH'(norm_index)};
        new_item.corner = corner;
    end

    assign corner_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid   = (count_reg != '0);
    assign head_item    = q_reg[rd_ptr_reg];
    assign push         = corner_valid && corner_ready;
    assign pop          = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// File: src/fcvd_back.sv
module fcvd_back
    import fcvd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  item_t                  head_item,
    output logic                   head_pop,
    output logic                   index_valid,
    input  logic                   index_ready,
    output logic [OUT_INDEX_W-1:0] out_index,
    output logic                   last_of_run,
    output logic                   table_full,
    output logic [COUNT_W-1:0]     unique_count
);

    back_state_t             state_reg, state_next;
    item_t                   cur_reg, cur_next;
    logic [CNT_W-1:0]        scan_addr_reg, scan_addr_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]       cmp_addr_reg, cmp_addr_next;
    logic [CNT_W-1:0]        entries_used_reg, entries_used_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic                    full_reg, full_next;
    logic [OUT_INDEX_W-1:0]  first_slot_reg, first_slot_next;
    logic [OUT_INDEX_W-1:0]  third_slot_reg, third_slot_next;
    logic [1:0]              res_k_reg, res_k_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_INDEX_W-1:0]  out_index_reg, out_index_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_full_reg, out_full_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;

    logic                    issue;
    logic                    hit;
    logic                    miss;
    logic                    tbl_full;
    logic                    wr_en;
    logic                    out_free;
    logic                    quad;
    logic                    last_res;
    logic                    load_out;
    logic [TRIPLE_W-1:0]     rd_data;
    logic [OUT_INDEX_W-1:0]  own_slot;

    fcvd_ram #(
        .WIDTH (TRIPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entries_used_reg[SLOT_W-1:0]),
        .wr_data (cur_reg.triple),
        .rd_en   (issue),
        .rd_addr (scan_addr_reg[SLOT_W-1:0]),
        .rd_data (rd_data)
    );

    assign issue    = (state_reg == ST_SCAN) && (scan_addr_reg < entries_used_reg);
    assign hit      = (state_reg == ST_SCAN) && cmp_valid_reg && (rd_data == cur_reg.triple);
    assign miss     = (state_reg == ST_SCAN) && !cmp_valid_reg && !issue;
    assign tbl_full = (entries_used_reg == CNT_W'(TABLE_DEPTH));
    assign wr_en    = miss && !tbl_full;
    assign out_free = !out_valid_reg || index_ready;
    assign quad     = (cur_reg.corner == CORNER_QUAD);
    assign last_res = !quad || (res_k_reg == 2'd2);
    assign load_out = (state_reg == ST_EMIT) && out_free;
    assign head_pop = (state_reg == ST_IDLE) && head_valid;
    assign own_slot = OUT_INDEX_W'(slot_reg);

    assign index_valid  = out_valid_reg;
    assign out_index    = out_index_reg;
    assign last_of_run  = out_last_reg;
    assign table_full   = out_full_reg;
    assign unique_count = out_count_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || miss)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out && last_res)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_next          = cur_reg;
        scan_addr_next    = scan_addr_reg;
        cmp_valid_next    = cmp_valid_reg;
        cmp_addr_next     = cmp_addr_reg;
        entries_used_next = entries_used_reg;
        slot_next         = slot_reg;
        full_next         = full_reg;
        first_slot_next   = first_slot_reg;
        third_slot_next   = third_slot_reg;
        res_k_next        = res_k_reg;
        out_valid_next    = out_valid_reg;
        out_index_next    = out_index_reg;
        out_last_next     = out_last_reg;
        out_full_next     = out_full_reg;
        out_count_next    = out_count_reg;

        if (index_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    cur_next       = head_item;
                    scan_addr_next = '0;
                    cmp_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // read one slot per cycle, compare the previous read
                cmp_valid_next = issue;
                if (issue)
                begin
                    cmp_addr_next  = scan_addr_reg[SLOT_W-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                if (hit)
                begin
                    slot_next      = cmp_addr_reg;
                    full_next      = 1'b0;
                    cmp_valid_next = 1'b0;
                    res_k_next     = '0;
                end
                else if (miss)
                begin
                    full_next  = tbl_full;
                    slot_next  = tbl_full ? '0 : entries_used_reg[SLOT_W-1:0];
                    res_k_next = '0;
                    if (!tbl_full)
                    begin
                        entries_used_next = entries_used_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = last_res;
                    out_full_next  = full_reg;
                    out_count_next = COUNT_W'(entries_used_reg);
                    res_k_next     = res_k_reg + 1'b1;
                    if (quad && (res_k_reg == 2'd0))
                    begin
                        out_index_next = first_slot_reg;
                    end
                    else if (quad && (res_k_reg == 2'd1))
                    begin
                        out_index_next = third_slot_reg;
                    end
                    else
                    begin
                        out_index_next = own_slot;
                    end
                    if (last_res && (cur_reg.corner == CORNER_FIRST))
                    begin
                        first_slot_next = own_slot;
                    end
                    else if (last_res && (cur_reg.corner == CORNER_THIRD))
                    begin
                        third_slot_next = own_slot;
                    end
                end
            end
            default:
            begin
                cmp_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_addr_reg    <= '0;
            cmp_valid_reg    <= 1'b0;
            entries_used_reg <= '0;
            first_slot_reg   <= '0;
            third_slot_reg   <= '0;
            res_k_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_addr_reg    <= scan_addr_next;
            cmp_valid_reg    <= cmp_valid_next;
            entries_used_reg <= entries_used_next;
            first_slot_reg   <= first_slot_next;
            third_slot_reg   <= third_slot_next;
            res_k_reg        <= res_k_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        cmp_addr_reg  <= cmp_addr_next;
        slot_reg      <= slot_next;
        full_reg      <= full_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
        out_full_reg  <= out_full_next;
        out_count_reg <= out_count_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entries_used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("unique count beyond table depth");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (entries_used_reg == $past(entries_used_reg) + 1'b1))
        else $error("insert did not advance unique count");

    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (state_reg == ST_SCAN))
        else $error("pending compare outside scan");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_full_reg) |-> tbl_full)
        else $error("full flag with free slots");
`endif

endmodule

// File: src/face_corner_vertex_dedup.sv
// face corner vertex dedup
// corner channel: corner_valid/corner_ready carry one face corner per
// transaction (pos_index, tex_index, norm_index, corner)
// index channel: index_valid/index_ready carry one index-buffer entry per
// transaction (out_index, last_of_run, table_full, unique_count)
// a corner 0..2 gives one transaction, a corner 3 gives three (corner 0 slot,
// corner 2 slot, own slot); last_of_run marks the final one
// a two-entry queue takes corners while the lookup engine is busy
// the lookup engine handles one corner at a time and pops the next only
// after the last result of the current one is registered; the triple
// table is read one slot per cycle in slot order, searching the N unique
// triples stored, up to a full table of 1024 triples
// reset clears the unique count and recorded quad slots; the table needs
// no clearing, only filled slots are searched
// a stalled index channel holds the result and stalls the lookup engine,
// the queue still takes corners until it fills
module face_corner_vertex_dedup
    import fcvd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   corner_valid,
    output logic                   corner_ready,
    input  logic [FIELD_W-1:0]     pos_index,
    input  logic [FIELD_W-1:0]     tex_index,
    input  logic [FIELD_W-1:0]     norm_index,
    input  logic [CORNER_W-1:0]    corner,
    output logic                   index_valid,
    input  logic                   index_ready,
    output logic [OUT_INDEX_W-1:0] out_index,
    output logic                   last_of_run,
    output logic                   table_full,
    output logic [COUNT_W-1:0]     unique_count
);

    logic  head_valid;
    item_t head_item;
    logic  head_pop;

    fcvd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .corner_valid (corner_valid),
        .corner_ready (corner_ready),
        .pos_index    (pos_index),
        .tex_index    (tex_index),
        .norm_index   (norm_index),
        .corner       (corner),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .head_pop     (head_pop)
    );

    fcvd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .head_pop     (head_pop),
        .index_valid  (index_valid),
        .index_ready  (index_ready),
        .out_index    (out_index),
        .last_of_run  (last_of_run),
        .table_full   (table_full),
        .unique_count (unique_count)
    );

endmodule
